[src/emvt_pkg.sv]
// ============================================================================
// Encoder multi-turn velocity tracker package
// Shared widths, register indexes and reset values of the tracker.
// ============================================================================
`default_nettype none

package emvt_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Configuration register widths.
    localparam int POLE_BITS   = 6;
    localparam int OFFSET_BITS = 12;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Register indexes on the configuration port.
    localparam cfg_index_t REG_POLE_COUNT  = cfg_index_t'(0);
    localparam cfg_index_t REG_ELEC_OFFSET = cfg_index_t'(1);

    // Register reset values.
    localparam logic [POLE_BITS-1:0]   POLE_RESET   = POLE_BITS'(7);
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = '0;

endpackage : emvt_pkg

`default_nettype wire

[src/emvt_in_stage.sv]
// ============================================================================
// Encoder tracker input stage
// Registers one accepted angle sample and holds it until the tracking stage
// takes it.
// ============================================================================
`default_nettype none

module emvt_in_stage #(
    parameter int ANGLE_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ANGLE_BITS-1:0] raw_angle,
    input  wire logic                  take,
    output logic                       held_valid,
    output logic [ANGLE_BITS-1:0]      held_raw
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [ANGLE_BITS-1:0] raw_reg;
    logic                  accept;

    // The stage is blocked only while it holds a sample that cannot move on.
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Sample register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= raw_angle;
        end
    end

    assign held_valid = valid_reg;
    assign held_raw   = raw_reg;

endmodule : emvt_in_stage

`default_nettype wire

[src/emvt_track.sv]
// ============================================================================
// Encoder tracker unwrap stage
// Holds the turn state and configuration, unwraps each sample and registers
// the full angle, turn count, velocity and electrical angle.
// ============================================================================
`default_nettype none

module emvt_track #(
    parameter int TURN_BITS  = 24,
    parameter int ANGLE_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire emvt_pkg::cfg_index_t              cfg_index,
    input  wire logic [emvt_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              held_valid,
    input  wire logic [ANGLE_BITS-1:0]             held_raw,
    output logic                                   take,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [TURN_BITS+ANGLE_BITS-1:0] multiturn_angle,
    output logic signed [TURN_BITS-1:0]            turn_count,
    output logic signed [ANGLE_BITS:0]             velocity_delta,
    output logic [ANGLE_BITS-1:0]                  electrical_angle
);

    localparam int PROD_BITS = emvt_pkg::POLE_BITS + ANGLE_BITS;
    localparam int OFFW_BITS = emvt_pkg::OFFSET_BITS + ANGLE_BITS;

    logic [emvt_pkg::POLE_BITS-1:0]   pole_reg;
    logic [emvt_pkg::OFFSET_BITS-1:0] offset_reg;
    logic [ANGLE_BITS-1:0]            prev_raw_reg;
    logic [TURN_BITS-1:0]             turn_reg;
    logic [TURN_BITS-1:0]             turn_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [TURN_BITS+ANGLE_BITS-1:0]  full_reg;
    logic [TURN_BITS-1:0]             turn_out_reg;
    logic [ANGLE_BITS:0]              vel_reg;
    logic [ANGLE_BITS:0]              vel_next;
    logic [ANGLE_BITS-1:0]            elec_reg;
    logic [ANGLE_BITS-1:0]            elec_next;

    logic                             fire;
    logic [ANGLE_BITS:0]              diff;
    logic [ANGLE_BITS:0]              diff_neg;
    logic [ANGLE_BITS-1:0]            mag;
    logic [ANGLE_BITS+2:0]            mag5;
    logic [ANGLE_BITS+2:0]            wrap_limit;
    logic                             wrapped;
    logic [PROD_BITS-1:0]             prod;
    logic [OFFW_BITS-1:0]             offset_wide;

    // The result register can take a new item when empty or being drained.
    assign take = !out_valid_reg || !out_stall;
    assign fire = held_valid && take;

    // Raw difference and its magnitude against the 0.8 turn threshold.
    assign diff       = {1'b0, held_raw} - {1'b0, prev_raw_reg};
    assign diff_neg   = -diff;
    assign mag        = diff[ANGLE_BITS] ? diff_neg[ANGLE_BITS-1:0] : diff[ANGLE_BITS-1:0];
    assign mag5       = {1'b0, mag, 2'b00} + {3'b000, mag};
    assign wrap_limit = {3'b100, {ANGLE_BITS{1'b0}}};
    assign wrapped    = mag5 > wrap_limit;

    // A forward step across zero reads as a large negative difference.
    always_comb
    begin
        turn_next = turn_reg;
        if (wrapped)
        begin
            if (diff[ANGLE_BITS])
            begin
                turn_next = turn_reg + TURN_BITS'(1);
            end
            else
            begin
                turn_next = turn_reg - TURN_BITS'(1);
            end
        end
    end

    // Only the low bits of the full angle reach the velocity output.
    assign vel_next = {turn_next[0], held_raw} - {turn_reg[0], prev_raw_reg};

    // Electrical angle, taken modulo one turn.
    assign prod        = {{emvt_pkg::POLE_BITS{1'b0}}, held_raw} *
                         {{ANGLE_BITS{1'b0}}, pole_reg};
    assign offset_wide = {{ANGLE_BITS{1'b0}}, offset_reg};
    assign elec_next   = prod[ANGLE_BITS-1:0] - offset_wide[ANGLE_BITS-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg   <= emvt_pkg::POLE_RESET;
            offset_reg <= emvt_pkg::OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                emvt_pkg::REG_POLE_COUNT:
                begin
                    pole_reg <= cfg_data[emvt_pkg::POLE_BITS-1:0];
                end
                emvt_pkg::REG_ELEC_OFFSET:
                begin
                    offset_reg <= cfg_data[emvt_pkg::OFFSET_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Tracking state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg  <= '0;
            turn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                prev_raw_reg <= held_raw;
                turn_reg     <= turn_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            full_reg     <= {turn_next, held_raw};
            turn_out_reg <= turn_next;
            vel_reg      <= vel_next;
            elec_reg     <= elec_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign multiturn_angle  = full_reg;
    assign turn_count       = turn_out_reg;
    assign velocity_delta   = vel_reg;
    assign electrical_angle = elec_reg;

endmodule : emvt_track

`default_nettype wire

[src/encoder_multiturn_velocity_tracker_top.sv]
// ============================================================================
// Encoder multi-turn velocity tracker
// Unwraps single-turn absolute encoder samples into a multi-turn angle and
// gives per-sample velocity and electrical angle.
// ============================================================================
// Usage:
// Samples enter on in_valid/in_stall with raw_angle; a request is taken at a
// rising edge with in_valid high and in_stall low. Each sample gives exactly
// one result on out_valid/out_stall carrying multiturn_angle, turn_count,
// velocity_delta and electrical_angle. out_valid rises once the sample has
// passed the input and result registers; throughput is one sample per cycle
// while out_stall is low, set by the unwrap loop that updates the turn
// counter. A stalled result holds; the input register still takes one
// further sample, after which in_stall rises until the result is taken.
// Reset clears the turn state, the previous sample and both valids, and loads
// the pole pair count with 7 and the electrical offset with 0. Registers are
// written through cfg_we, cfg_index and cfg_data, by the user only while the
// block is idle (not enforced by the block); unknown indexes are ignored.
// ============================================================================
`default_nettype none

module encoder_multiturn_velocity_tracker_top #(
    parameter int TURN_BITS  = 24,
    parameter int ANGLE_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire emvt_pkg::cfg_index_t               cfg_index,
    input  wire logic [emvt_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [ANGLE_BITS-1:0]              raw_angle,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [TURN_BITS+ANGLE_BITS-1:0]  multiturn_angle,
    output logic signed [TURN_BITS-1:0]             turn_count,
    output logic signed [ANGLE_BITS:0]              velocity_delta,
    output logic [ANGLE_BITS-1:0]                   electrical_angle
);

    logic                  take;
    logic                  held_valid;
    logic [ANGLE_BITS-1:0] held_raw;

    // Input sample register.
    emvt_in_stage #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_angle  (raw_angle),
        .take       (take),
        .held_valid (held_valid),
        .held_raw   (held_raw)
    );

    // Unwrap, velocity and electrical angle with the result register.
    emvt_track #(
        .TURN_BITS  (TURN_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_track (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .held_valid       (held_valid),
        .held_raw         (held_raw),
        .take             (take),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .multiturn_angle  (multiturn_angle),
        .turn_count       (turn_count),
        .velocity_delta   (velocity_delta),
        .electrical_angle (electrical_angle)
    );

endmodule : encoder_multiturn_velocity_tracker_top

`default_nettype wire

[src/emvt_checker.sv]
// ============================================================================
// Encoder tracker port checker
// Watches the tracker's ports and flags results that break its invariants.
// ============================================================================
`default_nettype none

module emvt_checker #(
    parameter int TURN_BITS  = 24,
    parameter int ANGLE_BITS = 12
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [TURN_BITS+ANGLE_BITS-1:0]    multiturn_angle,
    input wire logic [TURN_BITS-1:0]               turn_count,
    input wire logic [ANGLE_BITS:0]                velocity_delta,
    input wire logic [ANGLE_BITS-1:0]              electrical_angle
);

    logic [ANGLE_BITS:0]   vel_neg;
    logic [ANGLE_BITS:0]   vel_mag;
    logic [ANGLE_BITS+3:0] vel_mag5;
    logic [ANGLE_BITS+3:0] vel_limit;

    // Magnitude of the velocity, scaled by five for the 0.8 turn bound.
    assign vel_neg   = -velocity_delta;
    assign vel_mag   = velocity_delta[ANGLE_BITS] ? vel_neg : velocity_delta;
    assign vel_mag5  = {1'b0, vel_mag, 2'b00} + {3'b000, vel_mag};
    assign vel_limit = {4'b0100, {ANGLE_BITS{1'b0}}};

    // A stalled result keeps every field.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(multiturn_angle) &&
            $stable(turn_count) && $stable(velocity_delta) &&
            $stable(electrical_angle))
    else $error("stalled result changed");

    // The upper part of the full angle is the turn count.
    a_turn_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> multiturn_angle[TURN_BITS+ANGLE_BITS-1:ANGLE_BITS] == turn_count)
    else $error("full angle disagrees with turn count");

    // After unwrapping no step can exceed 0.8 turn.
    a_vel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vel_mag5 <= vel_limit)
    else $error("velocity exceeds unwrap bound");

    // Nothing leaves the block without a request having entered.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) || $past(in_stall, 1) ||
            $past(out_valid, 2))
    else $error("result without a preceding request");

endmodule : emvt_checker

bind encoder_multiturn_velocity_tracker_top emvt_checker #(
    .TURN_BITS  (TURN_BITS),
    .ANGLE_BITS (ANGLE_BITS)
) u_emvt_checker (.*);

`default_nettype wire
